FILE: hw/rtl/lppd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Length-prefixed packet deframer: shared package
// Types, register map and constants used by the deframer modules.
// ----------------------------------------------------------------------------
package lppd_pkg;

    // Header layout: 16-bit command, 16-bit extension length, 32-bit payload length.
    localparam int HDR_LEN   = 8;
    localparam int HDR_CNT_W = $clog2(HDR_LEN);
    localparam logic [HDR_CNT_W-1:0] HDR_LAST = HDR_CNT_W'(HDR_LEN - 1);

    // Configuration port geometry.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Register indexes (byte address divided by four).
    localparam logic [1:0] REG_PAY_LIMIT = 2'd0;
    localparam logic [1:0] REG_CHAT_CODE   = 2'd1;
    localparam logic [1:0] REG_LOGIN_CODE  = 2'd2;
    localparam logic [1:0] REG_REG_CODE    = 2'd3;

    // Reset values of the registers.
    localparam logic [31:0] RST_PAY_LIMIT = 32'(10 * 1024 * 1024);
    localparam logic [15:0] RST_CHAT_CODE   = 16'd0;
    localparam logic [15:0] RST_LOGIN_CODE  = 16'd1;
    localparam logic [15:0] RST_REG_CODE    = 16'd2;

    typedef enum logic [1:0] {
        FAULT_NONE        = 2'd0,
        FAULT_TOO_LARGE   = 2'd1,
        FAULT_CHAT_EXT    = 2'd2,
        FAULT_UNKNOWN_CMD = 2'd3
    } t_fault;

    typedef struct packed {
        logic [31:0] pay_limit;
        logic [15:0] chat_code;
        logic [15:0] login_code;
        logic [15:0] register_code;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        has_data;
        logic [15:0] command;
        logic        in_payload;
        logic        first_of_packet;
        logic        last_of_packet;
        t_fault      fault;
    } t_result;

endpackage

FILE: hw/rtl/lppd_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Length-prefixed packet deframer: configuration registers
// APB-style register file holding the payload limit and the command codes.
// ----------------------------------------------------------------------------
module lppd_cfg_regs
    import lppd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite & pready;

    // Register writes on the access cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pay_limit     <= RST_PAY_LIMIT;
            r_cfg.chat_code     <= RST_CHAT_CODE;
            r_cfg.login_code    <= RST_LOGIN_CODE;
            r_cfg.register_code <= RST_REG_CODE;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_PAY_LIMIT:   r_cfg.pay_limit     <= pwdata[31:0];
                REG_CHAT_CODE:   r_cfg.chat_code     <= pwdata[15:0];
                REG_LOGIN_CODE:  r_cfg.login_code    <= pwdata[15:0];
                REG_REG_CODE:    r_cfg.register_code <= pwdata[15:0];
                default:         r_cfg.pay_limit     <= r_cfg.pay_limit;
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb begin
        unique case (reg_idx)
            REG_PAY_LIMIT:   prdata = r_cfg.pay_limit;
            REG_CHAT_CODE:   prdata = {16'd0, r_cfg.chat_code};
            REG_LOGIN_CODE:  prdata = {16'd0, r_cfg.login_code};
            REG_REG_CODE:    prdata = {16'd0, r_cfg.register_code};
            default:         prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hw/rtl/lppd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Length-prefixed packet deframer: parser
// Gathers the header, checks it, and tags every body byte in a single pass.
// ----------------------------------------------------------------------------
module lppd_parser
    import lppd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    output logic       o_res_valid,
    output t_result    o_res
);

    logic [HDR_CNT_W-1:0] r_hdr_cnt,   n_hdr_cnt;
    logic [55:0]          r_hdr,       n_hdr;
    logic [15:0]          r_ext_left,  n_ext_left;
    logic [31:0]          r_pay_left,  n_pay_left;
    logic [15:0]          r_command,   n_command;
    logic                 r_first,     n_first;
    logic                 r_halted,    n_halted;
    logic                 r_in_body,   n_in_body;

    logic [63:0] hdr_full;
    logic [15:0] hdr_cmd;
    logic [15:0] hdr_ext;
    logic [31:0] hdr_pay;
    t_fault      hdr_fault;
    logic        last;

    assign hdr_full = {r_hdr, i_byte};
    assign hdr_cmd  = hdr_full[63:48];
    assign hdr_ext  = hdr_full[47:32];
    assign hdr_pay  = hdr_full[31:0];

    // Header check: payload limit first, then the chat rule, then unknown command.
    always_comb begin
        priority if (hdr_pay > i_cfg.pay_limit) begin
            hdr_fault = FAULT_TOO_LARGE;
        end else if (hdr_cmd == i_cfg.chat_code) begin
            hdr_fault = (hdr_ext != 16'd0) ? FAULT_CHAT_EXT : FAULT_NONE;
        end else if (hdr_cmd != i_cfg.login_code && hdr_cmd != i_cfg.register_code) begin
            hdr_fault = FAULT_UNKNOWN_CMD;
        end else begin
            hdr_fault = FAULT_NONE;
        end
    end

    // Next state and result for the accepted byte.
    always_comb begin
        n_hdr_cnt   = r_hdr_cnt;
        n_hdr       = r_hdr;
        n_ext_left  = r_ext_left;
        n_pay_left  = r_pay_left;
        n_command   = r_command;
        n_first     = r_first;
        n_halted    = r_halted;
        n_in_body   = r_in_body;
        o_res_valid = 1'b0;
        o_res       = '0;
        last        = 1'b0;

        if (i_accept && !r_halted) begin
            if (!r_in_body) begin
                n_hdr = hdr_full[55:0];
                if (r_hdr_cnt != HDR_LAST) begin
                    n_hdr_cnt = r_hdr_cnt + 1'b1;
                end else begin
                    n_hdr_cnt         = '0;
                    n_command         = hdr_cmd;
                    o_res.command     = hdr_cmd;
                    if (hdr_fault != FAULT_NONE) begin
                        n_halted    = 1'b1;
                        o_res_valid = 1'b1;
                        o_res.fault = hdr_fault;
                    end else if (hdr_ext == 16'd0 && hdr_pay == 32'd0) begin
                        // Empty body: a single marker result.
                        o_res_valid           = 1'b1;
                        o_res.first_of_packet = 1'b1;
                        o_res.last_of_packet  = 1'b1;
                    end else begin
                        n_in_body  = 1'b1;
                        n_ext_left = hdr_ext;
                        n_pay_left = hdr_pay;
                        n_first    = 1'b1;
                    end
                end
            end else begin
                // Extension bytes come before payload bytes.
                if (r_ext_left != 16'd0) begin
                    n_ext_left       = r_ext_left - 1'b1;
                    o_res.in_payload = 1'b0;
                end else begin
                    n_pay_left       = r_pay_left - 1'b1;
                    o_res.in_payload = 1'b1;
                end
                last                  = (n_ext_left == 16'd0) && (n_pay_left == 32'd0);
                n_first               = 1'b0;
                o_res_valid           = 1'b1;
                o_res.out_byte        = i_byte;
                o_res.has_data        = 1'b1;
                o_res.command         = r_command;
                o_res.first_of_packet = r_first;
                o_res.last_of_packet  = last;
                if (last) begin
                    n_in_body = 1'b0;
                end
            end
        end
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_cnt  <= '0;
            r_ext_left <= '0;
            r_pay_left <= '0;
            r_command  <= '0;
            r_first    <= 1'b0;
            r_halted   <= 1'b0;
            r_in_body  <= 1'b0;
        end else begin
            r_hdr_cnt  <= n_hdr_cnt;
            r_ext_left <= n_ext_left;
            r_pay_left <= n_pay_left;
            r_command  <= n_command;
            r_first    <= n_first;
            r_halted   <= n_halted;
            r_in_body  <= n_in_body;
        end
    end

    // Header shift register carries data only.
    always_ff @(posedge i_clk) begin
        r_hdr <= n_hdr;
    end

endmodule

FILE: hw/rtl/lppd_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Length-prefixed packet deframer: output register
// Holds one result beat and lets a new byte in while the sink takes it.
// ----------------------------------------------------------------------------
module lppd_out_reg
    import lppd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_take_ready,
    output logic    o_can_load,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    // Space is free when empty or when the held beat leaves this cycle.
    assign o_can_load = !r_valid || i_take_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

FILE: hw/rtl/length_prefixed_packet_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Length-prefixed packet deframer
// Splits a byte stream into packets with an 8-byte big-endian header and
// passes on the extension and payload bytes tagged with the command.
// ----------------------------------------------------------------------------
// The block takes one stream byte per cycle unless the output stalls, and gives
// at most one result beat per byte, in the cycle after the byte is accepted;
// throughput is one byte per cycle, limited only by the single output register,
// which takes a new result in the same cycle the sink takes the old one. Header
// bytes give no beat until the eighth, where the header is checked against the
// registers: a fault beat (has_data low) stops the block, which then accepts and
// drops every byte until reset. A packet with no body gives one marker beat with
// both first and last set. Register writes take effect at the next header.
// ----------------------------------------------------------------------------
module length_prefixed_packet_deframer
    import lppd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] in_byte
    // Output stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [23:0]           m_axis_tdata,   // [7:0] out_byte, [23:8] command
    output logic [4:0]            m_axis_tuser,   // [0] has_data, [1] in_payload,
                                                  // [2] first_of_packet, [4:3] fault
    output logic                  m_axis_tlast,   // last_of_packet
    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg    cfg;
    t_result parse_res;
    t_result out_res;
    logic    parse_valid;
    logic    can_load;
    logic    accept;

    assign s_axis_tready = can_load;
    assign accept        = s_axis_tvalid & s_axis_tready;

    lppd_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lppd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_accept    (accept),
        .i_byte      (s_axis_tdata),
        .o_res_valid (parse_valid),
        .o_res       (parse_res)
    );

    lppd_out_reg u_out_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (parse_valid),
        .i_res        (parse_res),
        .i_take_ready (m_axis_tready),
        .o_can_load   (can_load),
        .o_valid      (m_axis_tvalid),
        .o_res        (out_res)
    );

    // Pack the result beat onto the stream fields.
    assign m_axis_tdata = {out_res.command, out_res.out_byte};
    assign m_axis_tuser = {out_res.fault, out_res.first_of_packet,
                           out_res.in_payload, out_res.has_data};
    assign m_axis_tlast = out_res.last_of_packet;

endmodule
